// File: hw/rtl/zpba_pkg.sv
package zpba_pkg;

    // Field widths of the item, result and configuration words
    localparam int PG_W      = 12;
    localparam int END_W     = 13;
    localparam int CNT_W     = 7;
    localparam int CLS_W     = 2;
    localparam int KIND_W    = 2;
    localparam int ST_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 3;

    // Bitmap word geometry
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;

    // Zone loop counter, wide enough to step past the last zone
    localparam int ZCTR_W = 5;

    // Free takes at most this many pages minus one
    localparam int FREE_LIMIT = 64;

    // Parameter defaults
    localparam int PAGES_DEF   = 4096;
    localparam int ZONES_DEF   = 8;
    localparam int MAX_RUN_DEF = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DMA_LAST    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LAST = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        K_DEFINE  = 2'd0,
        K_ALLOC   = 2'd1,
        K_FREE    = 2'd2,
        K_RESERVE = 2'd3
    } kind_t;

    typedef enum logic [CLS_W-1:0] {
        CLS_DMA      = 2'd0,
        CLS_NORMAL   = 2'd1,
        CLS_UNMAPPED = 2'd2,
        CLS_INVALID  = 2'd3
    } cls_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_COUNT = 3'd1,
        ST_BAD_CLASS = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_ZONE_ERR  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_CLR_RD,
        BS_CLR_WR,
        BS_ZONE,
        BS_SCAN_RD,
        BS_SCAN,
        BS_MARK_RD,
        BS_MARK_LD,
        BS_MARK_BIT
    } bstate_t;

    // One classified request waiting for the back end
    typedef struct packed {
        kind_t              kind;
        status_t            pre;
        logic [PG_W-1:0]    page;
        logic [END_W-1:0]   end_page;
        logic [CNT_W-1:0]   count;
        cls_t               cls;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_link_t;

    typedef struct packed {
        logic [CFG_DAT_W-1:0] dma_last;
        logic [CFG_DAT_W-1:0] normal_last;
    } cfg_t;

endpackage

// File: hw/rtl/zpba_ifs.sv
interface zpba_item_if
    import zpba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [PG_W-1:0]   page_index;
    logic [END_W-1:0]  end_page;
    logic [CNT_W-1:0]  page_count;
    logic [CLS_W-1:0]  zone_class;

    modport source (output valid, kind, page_index, end_page, page_count, zone_class,
                    input ready);
    modport sink   (input valid, kind, page_index, end_page, page_count, zone_class,
                    output ready);
endinterface

interface zpba_result_if
    import zpba_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [ST_W-1:0] status;
    logic [PG_W-1:0] first_page;

    modport source (output valid, status, first_page, input ready);
    modport sink   (input valid, status, first_page, output ready);
endinterface

interface zpba_cfg_if
    import zpba_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/zpba_ram.sv
module zpba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/zpba_front.sv
module zpba_front
    import zpba_pkg::*;
#(
    parameter int PAGES   = PAGES_DEF,
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    zpba_item_if.sink   item,
    output q_link_t     head,
    input  logic        pop
);

    q_entry_t   q0_reg, q0_next;
    q_entry_t   q1_reg, q1_next;
    logic [1:0] cnt_reg, cnt_next;
    q_entry_t   cls_word;
    logic       push;

    assign item.ready = (cnt_reg != 2'd2);
    assign push       = item.valid && item.ready;

    // Classify the incoming word: checks that need no state
    always_comb
    begin
        cls_word.kind     = kind_t'(item.kind);
        cls_word.page     = item.page_index;
        cls_word.end_page = item.end_page;
        cls_word.count    = item.page_count;
        cls_word.cls      = cls_t'(item.zone_class);
        cls_word.pre      = ST_OK;
        unique case (kind_t'(item.kind))
            K_DEFINE:
            begin
                if (item.end_page <= {1'b0, item.page_index} ||
                    32'(item.end_page) > 32'(PAGES))
                begin
                    cls_word.pre = ST_ZONE_ERR;
                end
            end
            K_ALLOC:
            begin
                if (item.page_count == '0 || 32'(item.page_count) > 32'(MAX_RUN))
                begin
                    cls_word.pre = ST_BAD_COUNT;
                end
                else if (cls_t'(item.zone_class) == CLS_INVALID)
                begin
                    cls_word.pre = ST_BAD_CLASS;
                end
            end
            K_FREE:
            begin
                if (item.page_count == '0 || 32'(item.page_count) >= 32'(FREE_LIMIT))
                begin
                    cls_word.pre = ST_BAD_COUNT;
                end
            end
            K_RESERVE:
            begin
                if (item.page_count == '0 || 32'(item.page_count) > 32'(MAX_RUN))
                begin
                    cls_word.pre = ST_BAD_COUNT;
                end
            end
            default:
            begin
                cls_word.pre = ST_OK;
            end
        endcase
    end

    // Two-entry queue toward the back end
    always_comb
    begin
        logic [1:0] cnt_after;
        q0_next   = q0_reg;
        q1_next   = q1_reg;
        cnt_after = cnt_reg;
        if (pop)
        begin
            q0_next   = q1_reg;
            cnt_after = cnt_reg - 2'd1;
        end
        if (push)
        begin
            if (cnt_after == 2'd0)
            begin
                q0_next = cls_word;
            end
            else
            begin
                q1_next = cls_word;
            end
        end
        cnt_next = cnt_after + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.entry = q0_reg;

endmodule

// File: hw/rtl/zpba_back.sv
module zpba_back
    import zpba_pkg::*;
#(
    parameter int PAGES = PAGES_DEF,
    parameter int ZONES = ZONES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  q_link_t        head,
    output logic           pop,
    input  cfg_t           cfg,
    zpba_result_if.source  result
);

    localparam int WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int ZIW   = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int ZCW   = $clog2(ZONES + 1);

    // Lowest start of a run of n set bits in v; bit 7 flags a hit
    function automatic logic [7:0] find_run(logic [127:0] v, logic [CNT_W-1:0] n);
        logic [127:0] a [7];
        logic [127:0] r;
        logic [7:0]   off;
        logic         found;
        logic [6:0]   pos;
        a[0] = v;
        for (int k = 1; k < 7; k++)
        begin
            a[k] = a[k-1] & (a[k-1] >> (1 << (k - 1)));
        end
        r   = '1;
        off = 8'd0;
        for (int k = 0; k < 7; k++)
        begin
            if (n[k])
            begin
                r   = r & (a[k] >> off);
                off = off + 8'(1 << k);
            end
        end
        found = 1'b0;
        pos   = 7'd0;
        for (int i = 127; i >= 0; i--)
        begin
            if (r[i])
            begin
                found = 1'b1;
                pos   = 7'(i);
            end
        end
        return {found, pos};
    endfunction

    function automatic logic [WORD_BITS-1:0] range_mask(logic [BIT_W-1:0] lo,
                                                         logic [BIT_W-1:0] hi);
        return ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (6'd63 - hi));
    endfunction

    bstate_t              state_reg, state_next;
    logic [ZCW-1:0]       zd_reg, zd_next;
    logic [PG_W-1:0]      zf_reg [ZONES];
    logic [PG_W-1:0]      zf_next [ZONES];
    logic [END_W-1:0]     ze_reg [ZONES];
    logic [END_W-1:0]     ze_next [ZONES];
    logic [END_W-1:0]     zfree_reg [ZONES];
    logic [END_W-1:0]     zfree_next [ZONES];
    logic [END_W-1:0]     zused_reg [ZONES];
    logic [END_W-1:0]     zused_next [ZONES];
    logic [WORDS-1:0]     wvalid_reg, wvalid_next;
    logic                 rd_valid_reg;

    logic [END_W-1:0]     op_start_reg, op_start_next;
    logic [END_W-1:0]     op_end_reg, op_end_next;
    logic [CNT_W-1:0]     op_cnt_reg, op_cnt_next;
    logic [AW-1:0]        w_reg, w_next;
    logic [AW-1:0]        wlast_reg, wlast_next;
    logic [ZCTR_W-1:0]    z_reg, z_next;
    logic [ZCTR_W-1:0]    zhi_reg, zhi_next;
    logic [WORD_BITS-1:0] prev_reg, prev_next;
    logic [END_W-1:0]     mk_page_reg, mk_page_next;
    logic [CNT_W-1:0]     mk_left_reg, mk_left_next;
    logic                 mk_used_reg, mk_used_next;
    logic [WORD_BITS-1:0] wbuf_reg, wbuf_next;
    logic [PG_W-1:0]      first_reg, first_next;

    logic                 res_valid_reg, res_valid_next;
    status_t              res_status_reg, res_status_next;
    logic [PG_W-1:0]      res_first_reg, res_first_next;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata, rd_word;

    zpba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Words never written read as all used
    assign rd_word = rd_valid_reg ? ram_rdata : '1;

    // Sequencer: define, scan, mark
    always_comb
    begin
        q_entry_t             e;
        logic                 ovl;
        logic                 full;
        logic [ZIW-1:0]       zi;
        logic [END_W-1:0]     zs, zend;
        logic [BIT_W-1:0]     lo_b, hi_b;
        logic [WORD_BITS-1:0] cz;
        logic [7:0]           hit;
        logic [13:0]          base;
        logic [13:0]          j;
        logic [END_W-1:0]     np;
        logic [END_W-1:0]     last_pg;
        logic [WORD_BITS-1:0] nw;
        logic                 changed;
        logic                 seg_end;

        e = head.entry;
        state_next      = state_reg;
        zd_next         = zd_reg;
        zf_next         = zf_reg;
        ze_next         = ze_reg;
        zfree_next      = zfree_reg;
        zused_next      = zused_reg;
        wvalid_next     = wvalid_reg;
        op_start_next   = op_start_reg;
        op_end_next     = op_end_reg;
        op_cnt_next     = op_cnt_reg;
        w_next          = w_reg;
        wlast_next      = wlast_reg;
        z_next          = z_reg;
        zhi_next        = zhi_reg;
        prev_next       = prev_reg;
        mk_page_next    = mk_page_reg;
        mk_left_next    = mk_left_reg;
        mk_used_next    = mk_used_reg;
        wbuf_next       = wbuf_reg;
        first_next      = first_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = w_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = w_reg;

        ovl  = 1'b0;
        for (int i = 0; i < ZONES; i++)
        begin
            if (i < int'(zd_reg) && {1'b0, e.page} < ze_reg[i] &&
                {1'b0, zf_reg[i]} < e.end_page)
            begin
                ovl = 1'b1;
            end
        end
        full = (32'(zd_reg) >= 32'(ZONES));

        zi   = ZIW'(z_reg);
        zs   = {1'b0, zf_reg[zi]};
        zend = ze_reg[zi];

        // In-zone clear bits of the current scan or clear word
        lo_b    = (w_reg == AW'(op_start_reg >> BIT_W)) ? op_start_reg[BIT_W-1:0] : '0;
        last_pg = op_end_reg - 13'd1;
        hi_b    = (w_reg == wlast_reg) ? last_pg[BIT_W-1:0] : '1;
        cz      = ~rd_word & range_mask(lo_b, hi_b);
        hit     = find_run({cz, prev_reg}, op_cnt_reg);
        base    = 14'(w_reg) << BIT_W;
        j       = base + 14'(hit[6:0]) - 14'd64;

        // Single page update
        nw                       = wbuf_reg;
        nw[mk_page_reg[BIT_W-1:0]] = mk_used_reg;
        changed = (wbuf_reg[mk_page_reg[BIT_W-1:0]] != mk_used_reg);
        np      = mk_page_reg + 13'd1;
        seg_end = (mk_left_reg == 7'd1) || (np[BIT_W-1:0] == '0) ||
                  (32'(np) >= 32'(PAGES));

        unique case (state_reg)
            BS_IDLE:
            begin
                if (head.valid && !res_valid_reg)
                begin
                    pop = 1'b1;
                    if (e.pre != ST_OK)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = e.pre;
                        res_first_next  = '0;
                    end
                    else
                    begin
                        unique case (e.kind)
                            K_DEFINE:
                            begin
                                if (full || ovl)
                                begin
                                    res_valid_next  = 1'b1;
                                    res_status_next = ST_ZONE_ERR;
                                    res_first_next  = '0;
                                end
                                else
                                begin
                                    zf_next[ZIW'(zd_reg)]    = e.page;
                                    ze_next[ZIW'(zd_reg)]    = e.end_page;
                                    zfree_next[ZIW'(zd_reg)] = e.end_page - {1'b0, e.page};
                                    zused_next[ZIW'(zd_reg)] = '0;
                                    zd_next       = zd_reg + ZCW'(1);
                                    op_start_next = {1'b0, e.page};
                                    op_end_next   = e.end_page;
                                    w_next        = AW'(e.page >> BIT_W);
                                    wlast_next    = AW'((e.end_page - 13'd1) >> BIT_W);
                                    state_next    = BS_CLR_RD;
                                end
                            end
                            K_ALLOC:
                            begin
                                op_cnt_next = e.count;
                                state_next  = BS_ZONE;
                                unique case (e.cls)
                                    CLS_DMA:
                                    begin
                                        z_next   = '0;
                                        zhi_next = ZCTR_W'(cfg.dma_last);
                                    end
                                    CLS_NORMAL:
                                    begin
                                        z_next   = ZCTR_W'(cfg.dma_last);
                                        zhi_next = ZCTR_W'(cfg.normal_last);
                                    end
                                    default:
                                    begin
                                        z_next   = ZCTR_W'(cfg.normal_last);
                                        zhi_next = ZCTR_W'(zd_reg) - ZCTR_W'(1);
                                        if (zd_reg == '0)
                                        begin
                                            res_valid_next  = 1'b1;
                                            res_status_next = ST_NO_SPACE;
                                            res_first_next  = '0;
                                            state_next      = BS_IDLE;
                                        end
                                    end
                                endcase
                            end
                            default:
                            begin
                                mk_page_next = {1'b0, e.page};
                                mk_left_next = e.count;
                                mk_used_next = (e.kind == K_RESERVE);
                                first_next   = '0;
                                state_next   = BS_MARK_RD;
                            end
                        endcase
                    end
                end
            end

            BS_CLR_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = w_reg;
                state_next = BS_CLR_WR;
            end

            BS_CLR_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = w_reg;
                ram_wdata = rd_word & ~range_mask(lo_b, hi_b);
                wvalid_next[w_reg] = 1'b1;
                if (w_reg == wlast_reg)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_OK;
                    res_first_next  = '0;
                    state_next      = BS_IDLE;
                end
                else
                begin
                    w_next     = w_reg + AW'(1);
                    state_next = BS_CLR_RD;
                end
            end

            // Pick the next zone of the class worth scanning
            BS_ZONE:
            begin
                if (z_reg > zhi_reg || z_reg >= ZCTR_W'(zd_reg))
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_NO_SPACE;
                    res_first_next  = '0;
                    state_next      = BS_IDLE;
                end
                else if (zfree_reg[zi] < END_W'(op_cnt_reg) ||
                         (zend - zs) < END_W'(op_cnt_reg))
                begin
                    z_next = z_reg + ZCTR_W'(1);
                end
                else
                begin
                    op_start_next = zs;
                    op_end_next   = zend;
                    w_next        = AW'(zs >> BIT_W);
                    wlast_next    = AW'((zend - 13'd1) >> BIT_W);
                    prev_next     = '0;
                    state_next    = BS_SCAN_RD;
                end
            end

            BS_SCAN_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = w_reg;
                state_next = BS_SCAN;
            end

            // One word per cycle; run carries over from the previous word
            BS_SCAN:
            begin
                if (hit[7])
                begin
                    first_next   = j[PG_W-1:0];
                    mk_page_next = j[END_W-1:0];
                    mk_left_next = op_cnt_reg;
                    mk_used_next = 1'b1;
                    state_next   = BS_MARK_RD;
                end
                else if (w_reg == wlast_reg)
                begin
                    z_next     = z_reg + ZCTR_W'(1);
                    state_next = BS_ZONE;
                end
                else
                begin
                    prev_next = cz;
                    w_next    = w_reg + AW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = w_reg + AW'(1);
                end
            end

            BS_MARK_RD:
            begin
                if (32'(mk_page_reg) >= 32'(PAGES))
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_OK;
                    res_first_next  = first_reg;
                    state_next      = BS_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(mk_page_reg >> BIT_W);
                    state_next = BS_MARK_LD;
                end
            end

            BS_MARK_LD:
            begin
                wbuf_next  = rd_word;
                state_next = BS_MARK_BIT;
            end

            // One page per cycle while the run stays within one word, counts follow each changed bit
            BS_MARK_BIT:
            begin
                wbuf_next    = nw;
                mk_page_next = np;
                mk_left_next = mk_left_reg - 7'd1;
                if (changed)
                begin
                    for (int i = 0; i < ZONES; i++)
                    begin
                        if (i < int'(zd_reg) && mk_page_reg >= {1'b0, zf_reg[i]} &&
                            mk_page_reg < ze_reg[i])
                        begin
                            if (mk_used_reg)
                            begin
                                zused_next[i] = zused_reg[i] + 13'd1;
                                zfree_next[i] = zfree_reg[i] - 13'd1;
                            end
                            else
                            begin
                                zused_next[i] = zused_reg[i] - 13'd1;
                                zfree_next[i] = zfree_reg[i] + 13'd1;
                            end
                        end
                    end
                end
                if (seg_end)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(mk_page_reg >> BIT_W);
                    ram_wdata = nw;
                    wvalid_next[AW'(mk_page_reg >> BIT_W)] = 1'b1;
                    if (mk_left_reg == 7'd1 || 32'(np) >= 32'(PAGES))
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = ST_OK;
                        res_first_next  = first_reg;
                        state_next      = BS_IDLE;
                    end
                    else
                    begin
                        state_next = BS_MARK_RD;
                    end
                end
            end

            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            zd_reg        <= '0;
            wvalid_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            zd_reg        <= zd_next;
            wvalid_reg    <= wvalid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zf_reg         <= zf_next;
        ze_reg         <= ze_next;
        zfree_reg      <= zfree_next;
        zused_reg      <= zused_next;
        op_start_reg   <= op_start_next;
        op_end_reg     <= op_end_next;
        op_cnt_reg     <= op_cnt_next;
        w_reg          <= w_next;
        wlast_reg      <= wlast_next;
        z_reg          <= z_next;
        zhi_reg        <= zhi_next;
        prev_reg       <= prev_next;
        mk_page_reg    <= mk_page_next;
        mk_left_reg    <= mk_left_next;
        mk_used_reg    <= mk_used_next;
        wbuf_reg       <= wbuf_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        if (ram_re)
        begin
            rd_valid_reg <= wvalid_reg[ram_raddr];
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.status     = res_status_reg;
    assign result.first_page = res_first_reg;

endmodule

// File: hw/rtl/zoned_page_bitmap_allocator.sv
// Steps: a rejected word goes straight to its result; define reads and writes back
// each bitmap word of the zone; free and reserve read each word touched, update each
// page and write the word back; alloc tries each zone of the class in turn, scans its
// words and then marks the run. One word at a time: the next starts once the last
// result is taken. The bitmap RAM has one read port and one write port.
// Reset: bitmap reads all used through per-word valid bits, zone table empty,
// class bounds zero; no clearing pass.
module zoned_page_bitmap_allocator
    import zpba_pkg::*;
#(
    parameter int PAGES   = PAGES_DEF,
    parameter int ZONES   = ZONES_DEF,
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    zpba_item_if.sink      item,
    zpba_result_if.source  result,
    zpba_cfg_if.sink       cfg
);

    cfg_t    cfg_reg, cfg_next;
    q_link_t head;
    logic    pop;

    // Class bound registers
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DMA_LAST:    cfg_next.dma_last    = cfg.data;
                CFG_NORMAL_LAST: cfg_next.normal_last = cfg.data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    zpba_front #(
        .PAGES   (PAGES),
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .head  (head),
        .pop   (pop)
    );

    zpba_back #(
        .PAGES (PAGES),
        .ZONES (ZONES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .cfg    (cfg_reg),
        .result (result)
    );

endmodule
